/* rtl/abnf_lex_pkg.sv */
// Shared types, codes and helper functions for the ABNF token lexer.
// No dependencies; used by every module of the block.
package abnf_lex_pkg;

	// Defaults for the top-level parameters
	localparam int HASH_MODULUS_DEF = 1023;
	localparam int DEPTH_BITS_DEF   = 8;

	// Depth of the bundle queue between front and back
	localparam int QDEPTH = 2;

	// Token types
	localparam logic [4:0] TT_ERROR    = 5'd0;
	localparam logic [4:0] TT_COMMENT  = 5'd1;
	localparam logic [4:0] TT_RULEDEF  = 5'd2;
	localparam logic [4:0] TT_AMEND    = 5'd3;
	localparam logic [4:0] TT_HEXMODE  = 5'd4;
	localparam logic [4:0] TT_BINMODE  = 5'd5;
	localparam logic [4:0] TT_DECMODE  = 5'd6;
	localparam logic [4:0] TT_SLASH    = 5'd7;
	localparam logic [4:0] TT_STAR     = 5'd8;
	localparam logic [4:0] TT_LPAREN   = 5'd9;
	localparam logic [4:0] TT_RPAREN   = 5'd10;
	localparam logic [4:0] TT_LBRACKET = 5'd11;
	localparam logic [4:0] TT_RBRACKET = 5'd12;
	localparam logic [4:0] TT_DASH     = 5'd13;
	localparam logic [4:0] TT_DOT      = 5'd14;
	localparam logic [4:0] TT_NUMBER   = 5'd15;
	localparam logic [4:0] TT_HEXNUM   = 5'd16;
	localparam logic [4:0] TT_QUOTED   = 5'd17;
	localparam logic [4:0] TT_PROSE    = 5'd18;
	localparam logic [4:0] TT_RULENAME = 5'd19;
	localparam logic [4:0] TT_LINEEND  = 5'd20;

	// Error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_LITERAL = 3'd1;
	localparam logic [2:0] ERR_QUOTE   = 3'd2;
	localparam logic [2:0] ERR_ANGLE   = 3'd3;
	localparam logic [2:0] ERR_CHAR    = 3'd4;
	localparam logic [2:0] ERR_PAREN   = 3'd5;
	localparam logic [2:0] ERR_BRACKET = 3'd6;

	// One result beat (last is added by the back end)
	typedef struct packed {
		logic [4:0]  token_type;
		logic [2:0]  error_code;
		logic [15:0] line_number;
		logic [15:0] column;
		logic [15:0] token_length;
		logic [9:0]  rule_hash;
		logic        text_done;
	} lex_res_t;

	// All results caused by one input beat
	typedef struct packed {
		logic [2:0]         count;
		lex_res_t [3:0]     res;
	} lex_bundle_t;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic [7:0] fold8(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
	endfunction

	// Append one result to a bundle; drops beyond four
	function automatic lex_bundle_t add_res(
		input lex_bundle_t b,
		input logic [4:0]  ttype,
		input logic [2:0]  err,
		input logic [15:0] line,
		input logic [15:0] col,
		input logic [15:0] len,
		input logic [9:0]  hash,
		input logic        done
	);
		lex_bundle_t o;
		o = b;
		if (b.count < 3'd4) begin
			o.res[b.count[1:0]].token_type   = ttype;
			o.res[b.count[1:0]].error_code   = err;
			o.res[b.count[1:0]].line_number  = line;
			o.res[b.count[1:0]].column       = col;
			o.res[b.count[1:0]].token_length = len;
			o.res[b.count[1:0]].rule_hash    = hash;
			o.res[b.count[1:0]].text_done    = done;
			o.count = b.count + 3'd1;
		end
		return o;
	endfunction

endpackage

/* rtl/abnf_lex_front.sv */
// Front end of the ABNF token lexer: classifies each byte, keeps the lexer
// state and builds the bundle of results for that byte. Uses abnf_lex_pkg.
module abnf_lex_front #(
	parameter int HASH_MODULUS = abnf_lex_pkg::HASH_MODULUS_DEF,
	parameter int DEPTH_BITS   = abnf_lex_pkg::DEPTH_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      acc,
	input  logic [7:0]                text_byte,
	input  logic                      end_of_text,
	output abnf_lex_pkg::lex_bundle_t bundle,
	output logic                      bundle_push
);

	localparam int HW = $clog2(HASH_MODULUS);
	localparam int EW = HW + 5;
	localparam logic [EW-1:0] M1 = EW'(HASH_MODULUS);
	localparam logic [EW-1:0] M2 = M1 << 1;
	localparam logic [EW-1:0] M4 = M1 << 2;
	localparam logic [EW-1:0] M8 = M1 << 3;
	localparam logic [HW-1:0] POW13 = HW'(13 % HASH_MODULUS);
	localparam logic [DEPTH_BITS-1:0] DMAX = {DEPTH_BITS{1'b1}};

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum logic [3:0] {
		PK_NONE, PK_CR, PK_EQ, PK_PCT, PK_COMMENT,
		PK_QUOTED, PK_PROSE, PK_NUMBER, PK_HEX, PK_NAME
	} pend_t;

	// Folded byte value reduced by the modulus, one entry per byte
	function automatic logic [256*HW-1:0] build_fold_tbl();
		logic [256*HW-1:0] t;
		int f;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			f = ((i >= 65) && (i <= 90)) ? i + 32 : i;
			t[i*HW +: HW] = HW'(f % HASH_MODULUS);
		end
		return t;
	endfunction

	localparam logic [256*HW-1:0] FOLD_TBL = build_fold_tbl();

	// x * 13, widened
	function automatic logic [EW-1:0] mul13(input logic [HW-1:0] x);
		return (EW'(x) << 3) + (EW'(x) << 2) + EW'(x);
	endfunction

	// Reduce a value below 16*modulus
	function automatic logic [HW-1:0] red16(input logic [EW-1:0] v);
		logic [EW-1:0] t;
		t = v;
		if (t >= M8) t = t - M8;
		if (t >= M4) t = t - M4;
		if (t >= M2) t = t - M2;
		if (t >= M1) t = t - M1;
		return t[HW-1:0];
	endfunction

	// Sum of two residues, reduced
	function automatic logic [HW-1:0] add_mod(input logic [HW-1:0] a, input logic [HW-1:0] b);
		logic [HW:0] s;
		s = (HW+1)'(a) + (HW+1)'(b);
		if (s >= (HW+1)'(HASH_MODULUS)) s = s - (HW+1)'(HASH_MODULUS);
		return s[HW-1:0];
	endfunction

	pend_t                  pend_q, v_pend;
	logic                   hex_q, v_hex;
	logic [15:0]            line_q, v_line;
	logic [15:0]            col_q, v_col;
	logic [15:0]            start_q, v_start;
	logic [15:0]            len_q, v_len;
	logic [HW-1:0]          sum_q, v_sum;
	logic [HW-1:0]          pow_q, v_pow;
	logic [HW-1:0]          term_q, v_term;
	logic [DEPTH_BITS-1:0]  paren_q, v_paren;
	logic [DEPTH_BITS-1:0]  brack_q, v_brack;
	logic                   err_q, v_err;

	abnf_lex_pkg::lex_bundle_t bun;
	logic [7:0]    b;
	logic [7:0]    bf;
	logic [HW-1:0] fold_mod;
	logic [9:0]    name_hash;
	logic          go_fresh;
	logic          skip;
	logic [4:0]    single;
	logic [4:0]    pct_type;

	assign b         = text_byte;
	assign bf        = abnf_lex_pkg::fold8(text_byte);
	assign fold_mod  = FOLD_TBL[text_byte*HW +: HW];
	assign name_hash = 10'(add_mod(term_q, sum_q));

	// Next state and result bundle for the byte on the input
	always_comb begin
		v_pend   = pend_q;
		v_hex    = hex_q;
		v_line   = line_q;
		v_col    = col_q;
		v_start  = start_q;
		v_len    = len_q;
		v_sum    = sum_q;
		v_pow    = pow_q;
		v_term   = term_q;
		v_paren  = paren_q;
		v_brack  = brack_q;
		v_err    = err_q;
		bun      = '0;
		go_fresh = 1'b0;
		skip     = 1'b0;
		single   = 5'd0;
		pct_type = 5'd0;

		if (end_of_text) begin
			// flush pending token
			if (!v_err) begin
				unique case (pend_q)
					PK_CR: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_LINEEND,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, 16'd1, 10'd0, 1'b0);
						v_line = abnf_lex_pkg::inc16(v_line);
						v_col  = 16'd0;
					end
					PK_EQ: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_RULEDEF,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, 16'd1, 10'd0, 1'b0);
						if (paren_q != '0 || brack_q != '0) begin
							bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
								(paren_q != '0) ? abnf_lex_pkg::ERR_PAREN
								: abnf_lex_pkg::ERR_BRACKET,
								v_line, start_q, 16'd0, 10'd0, 1'b0);
							v_err = 1'b1;
						end
					end
					PK_PCT: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
							abnf_lex_pkg::ERR_LITERAL, v_line, start_q, 16'd0, 10'd0, 1'b0);
						v_err = 1'b1;
					end
					PK_QUOTED: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
							abnf_lex_pkg::ERR_QUOTE, v_line, start_q, 16'd0, 10'd0, 1'b0);
						v_err = 1'b1;
					end
					PK_PROSE: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
							abnf_lex_pkg::ERR_ANGLE, v_line, start_q, 16'd0, 10'd0, 1'b0);
						v_err = 1'b1;
					end
					PK_COMMENT: bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_COMMENT,
						abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
					PK_NUMBER: bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_NUMBER,
						abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
					PK_HEX: bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_HEXNUM,
						abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
					PK_NAME: bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_RULENAME,
						abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, name_hash, 1'b0);
					default: ;
				endcase
			end
			// leftover nesting
			if (!v_err) begin
				if (paren_q != '0)
					bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
						abnf_lex_pkg::ERR_PAREN, v_line, v_col, 16'd0, 10'd0, 1'b0);
				if (brack_q != '0)
					bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
						abnf_lex_pkg::ERR_BRACKET, v_line, v_col, 16'd0, 10'd0, 1'b0);
			end
			bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
				abnf_lex_pkg::ERR_NONE, v_line, v_col, 16'd0, 10'd0, 1'b1);
			// back to reset state
			v_pend  = PK_NONE;
			v_hex   = 1'b0;
			v_line  = 16'd1;
			v_col   = 16'd0;
			v_start = 16'd0;
			v_len   = 16'd0;
			v_sum   = '0;
			v_pow   = HW'(1);
			v_term  = '0;
			v_paren = '0;
			v_brack = '0;
			v_err   = 1'b0;
		end else if (!err_q) begin
			// continue or close the pending token
			unique case (pend_q)
				PK_CR: begin
					bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_LINEEND,
						abnf_lex_pkg::ERR_NONE, v_line, start_q,
						(b == CH_LF) ? 16'd2 : 16'd1, 10'd0, 1'b0);
					v_line = abnf_lex_pkg::inc16(v_line);
					v_col  = 16'd0;
					v_hex  = 1'b0;
					v_pend = PK_NONE;
					go_fresh = (b != CH_LF);
				end
				PK_EQ: begin
					v_pend = PK_NONE;
					v_hex  = 1'b0;
					bun = abnf_lex_pkg::add_res(bun,
						(b == "/") ? abnf_lex_pkg::TT_AMEND : abnf_lex_pkg::TT_RULEDEF,
						abnf_lex_pkg::ERR_NONE, v_line, start_q,
						(b == "/") ? 16'd2 : 16'd1, 10'd0, 1'b0);
					if (paren_q != '0 || brack_q != '0) begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
							(paren_q != '0) ? abnf_lex_pkg::ERR_PAREN
							: abnf_lex_pkg::ERR_BRACKET,
							v_line, start_q, 16'd0, 10'd0, 1'b0);
						v_err = 1'b1;
					end
					if (b == "/")
						v_col = abnf_lex_pkg::inc16(col_q);
					else
						go_fresh = !v_err;
				end
				PK_PCT: begin
					v_pend = PK_NONE;
					if (bf == "x")      pct_type = abnf_lex_pkg::TT_HEXMODE;
					else if (bf == "b") pct_type = abnf_lex_pkg::TT_BINMODE;
					else if (bf == "d") pct_type = abnf_lex_pkg::TT_DECMODE;
					if (pct_type == 5'd0) begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
							abnf_lex_pkg::ERR_LITERAL, v_line, start_q, 16'd0, 10'd0, 1'b0);
						v_err = 1'b1;
					end else begin
						bun = abnf_lex_pkg::add_res(bun, pct_type,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, 16'd2, 10'd0, 1'b0);
						v_hex = (pct_type == abnf_lex_pkg::TT_HEXMODE);
						v_col = abnf_lex_pkg::inc16(col_q);
					end
				end
				PK_COMMENT: begin
					if (b != CH_LF && b != CH_CR) begin
						v_len = abnf_lex_pkg::inc16(len_q);
						v_col = abnf_lex_pkg::inc16(col_q);
					end else begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_COMMENT,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
						v_pend = PK_NONE;
						go_fresh = 1'b1;
					end
				end
				PK_QUOTED, PK_PROSE: begin
					v_len = abnf_lex_pkg::inc16(len_q);
					v_col = abnf_lex_pkg::inc16(col_q);
					if ((pend_q == PK_QUOTED && b == "\"") || (pend_q == PK_PROSE && b == ">")) begin
						bun = abnf_lex_pkg::add_res(bun,
							(pend_q == PK_QUOTED) ? abnf_lex_pkg::TT_QUOTED
							: abnf_lex_pkg::TT_PROSE,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, v_len, 10'd0, 1'b0);
						v_pend = PK_NONE;
					end
				end
				PK_NUMBER: begin
					if (abnf_lex_pkg::is_digit(b)) begin
						v_len = abnf_lex_pkg::inc16(len_q);
						v_col = abnf_lex_pkg::inc16(col_q);
					end else begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_NUMBER,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
						v_pend = PK_NONE;
						go_fresh = 1'b1;
					end
				end
				PK_HEX: begin
					if (abnf_lex_pkg::is_xdigit(b)) begin
						v_len = abnf_lex_pkg::inc16(len_q);
						v_col = abnf_lex_pkg::inc16(col_q);
					end else begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_HEXNUM,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, 10'd0, 1'b0);
						v_pend = PK_NONE;
						go_fresh = 1'b1;
					end
				end
				PK_NAME: begin
					if (abnf_lex_pkg::is_alpha(b) || abnf_lex_pkg::is_digit(b) || b == "-") begin
						// running hash: sum*13+c, power*13, len*power
						v_sum = red16(mul13(sum_q) + EW'(fold_mod));
						v_pow = red16(mul13(pow_q));
						if (len_q == 16'hFFFF)
							v_term = red16(mul13(term_q));
						else
							v_term = red16(mul13(add_mod(term_q, pow_q)));
						v_len = abnf_lex_pkg::inc16(len_q);
						v_col = abnf_lex_pkg::inc16(col_q);
					end else begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_RULENAME,
							abnf_lex_pkg::ERR_NONE, v_line, start_q, len_q, name_hash, 1'b0);
						v_pend = PK_NONE;
						go_fresh = 1'b1;
					end
				end
				default: begin
					v_pend = PK_NONE;
					go_fresh = 1'b1;
				end
			endcase

			// byte starts a new token
			if (go_fresh) begin
				v_start = v_col;
				v_len   = 16'd1;
				unique case (b)
					" ", CH_TAB: v_hex = 1'b0;
					CH_CR: v_pend = PK_CR;
					CH_LF: begin
						bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_LINEEND,
							abnf_lex_pkg::ERR_NONE, v_line, v_col, 16'd1, 10'd0, 1'b0);
						v_line = abnf_lex_pkg::inc16(v_line);
						v_col  = 16'd0;
						v_hex  = 1'b0;
						v_pend = PK_NONE;
						skip   = 1'b1;
					end
					";": begin
						v_pend = PK_COMMENT;
						v_hex  = 1'b0;
					end
					"/": single = abnf_lex_pkg::TT_SLASH;
					"*": single = abnf_lex_pkg::TT_STAR;
					"(": single = abnf_lex_pkg::TT_LPAREN;
					")": single = abnf_lex_pkg::TT_RPAREN;
					"[": single = abnf_lex_pkg::TT_LBRACKET;
					"]": single = abnf_lex_pkg::TT_RBRACKET;
					"-": single = abnf_lex_pkg::TT_DASH;
					".": single = abnf_lex_pkg::TT_DOT;
					"=": v_pend = PK_EQ;
					"%": v_pend = PK_PCT;
					"\"": begin
						v_pend = PK_QUOTED;
						v_hex  = 1'b0;
					end
					"<": begin
						v_pend = PK_PROSE;
						v_hex  = 1'b0;
					end
					default: begin
						if (v_hex && abnf_lex_pkg::is_xdigit(b)) begin
							v_pend = PK_HEX;
						end else if (abnf_lex_pkg::is_digit(b)) begin
							v_pend = PK_NUMBER;
							v_hex  = 1'b0;
						end else if (abnf_lex_pkg::is_alpha(b)) begin
							v_pend = PK_NAME;
							v_hex  = 1'b0;
							v_sum  = fold_mod;
							v_pow  = POW13;
							v_term = POW13;
						end else begin
							bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
								abnf_lex_pkg::ERR_CHAR, v_line, v_col, 16'd0, 10'd0, 1'b0);
							v_err  = 1'b1;
							v_pend = PK_NONE;
							skip   = 1'b1;
						end
					end
				endcase

				// one-byte tokens and nesting
				if (single != 5'd0) begin
					bun = abnf_lex_pkg::add_res(bun, single, abnf_lex_pkg::ERR_NONE,
						v_line, v_col, 16'd1, 10'd0, 1'b0);
					if (single != abnf_lex_pkg::TT_DASH && single != abnf_lex_pkg::TT_DOT)
						v_hex = 1'b0;
					if (single == abnf_lex_pkg::TT_LPAREN) begin
						if (paren_q != DMAX) v_paren = paren_q + 1'b1;
					end else if (single == abnf_lex_pkg::TT_LBRACKET) begin
						if (brack_q != DMAX) v_brack = brack_q + 1'b1;
					end else if (single == abnf_lex_pkg::TT_RPAREN) begin
						if (paren_q == '0) begin
							bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
								abnf_lex_pkg::ERR_PAREN, v_line, v_col, 16'd0, 10'd0, 1'b0);
							v_err = 1'b1;
							skip  = 1'b1;
						end else begin
							v_paren = paren_q - 1'b1;
						end
					end else if (single == abnf_lex_pkg::TT_RBRACKET) begin
						if (brack_q == '0) begin
							bun = abnf_lex_pkg::add_res(bun, abnf_lex_pkg::TT_ERROR,
								abnf_lex_pkg::ERR_BRACKET, v_line, v_col, 16'd0, 10'd0, 1'b0);
							v_err = 1'b1;
							skip  = 1'b1;
						end else begin
							v_brack = brack_q - 1'b1;
						end
					end
				end
				if (!skip)
					v_col = abnf_lex_pkg::inc16(v_col);
			end
		end
	end

	assign bundle      = bun;
	assign bundle_push = acc && (bun.count != 3'd0);

	// Lexer state, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= PK_NONE;
			hex_q   <= 1'b0;
			line_q  <= 16'd1;
			col_q   <= 16'd0;
			start_q <= 16'd0;
			len_q   <= 16'd0;
			sum_q   <= '0;
			pow_q   <= HW'(1);
			term_q  <= '0;
			paren_q <= '0;
			brack_q <= '0;
			err_q   <= 1'b0;
		end else if (acc) begin
			pend_q  <= v_pend;
			hex_q   <= v_hex;
			line_q  <= v_line;
			col_q   <= v_col;
			start_q <= v_start;
			len_q   <= v_len;
			sum_q   <= v_sum;
			pow_q   <= v_pow;
			term_q  <= v_term;
			paren_q <= v_paren;
			brack_q <= v_brack;
			err_q   <= v_err;
		end
	end

	// End of text always yields results and leaves the reset state
	a_eot_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_text) |-> bundle_push)
		else $error("end of text produced no results");
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_text) |=> (!err_q && pend_q == PK_NONE && line_q == 16'd1
			&& paren_q == '0 && brack_q == '0))
		else $error("state not cleared after end of text");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && err_q && !end_of_text) |-> !bundle_push)
		else $error("results after a latched error");

endmodule

/* rtl/abnf_lex_queue.sv */
// Short bundle queue between the lexer front and back ends.
// Uses abnf_lex_pkg for the bundle type and depth.
module abnf_lex_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  abnf_lex_pkg::lex_bundle_t wdata,
	output logic                      full,
	output logic                      rvalid,
	output abnf_lex_pkg::lex_bundle_t rdata,
	input  logic                      pop
);

	localparam int PW = (abnf_lex_pkg::QDEPTH > 1) ? $clog2(abnf_lex_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(abnf_lex_pkg::QDEPTH + 1);
	localparam logic [PW-1:0] PLAST = PW'(abnf_lex_pkg::QDEPTH - 1);
	localparam logic [CW-1:0] CFULL = CW'(abnf_lex_pkg::QDEPTH);

	abnf_lex_pkg::lex_bundle_t mem_q [abnf_lex_pkg::QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CFULL);
	assign rvalid  = (cnt_q != '0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == PLAST) ? '0 : wptr_q + 1'b1;
			if (do_pop)  rptr_q <= (rptr_q == PLAST) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle pushed into a full queue");

endmodule

/* rtl/abnf_lex_back.sv */
// Back end of the ABNF token lexer: takes bundles from the queue and hands
// out their results one beat at a time. Uses abnf_lex_pkg.
module abnf_lex_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rvalid,
	input  abnf_lex_pkg::lex_bundle_t rdata,
	output logic                      rpop,
	output logic                      empty,
	input  logic                      pop,
	output abnf_lex_pkg::lex_res_t    cur,
	output logic                      last
);

	abnf_lex_pkg::lex_bundle_t hold_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       is_last;
	logic       load;

	assign is_last = ({1'b0, idx_q} == (hold_q.count - 3'd1));
	assign load    = rvalid && (!valid_q || (pop && is_last));
	assign rpop    = load;
	assign empty   = !valid_q;
	assign cur     = hold_q.res[idx_q];
	assign last    = is_last;

	// Bundle being drained
	always_ff @(posedge clk) begin
		if (load) hold_q <= rdata;
	end

	// Drain position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (pop && valid_q) begin
			if (is_last) valid_q <= 1'b0;
			else         idx_q   <= idx_q + 2'd1;
		end
	end

	a_hold_sane: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (hold_q.count != 3'd0 && hold_q.count <= 3'd4
			&& {1'b0, idx_q} < hold_q.count))
		else $error("drain index outside the held bundle");

endmodule

/* rtl/abnf_token_lexer_unit.sv */
// ABNF token lexer, top level.
// Channels: input queue side (push/full) carries text_byte and end_of_text;
// result queue side (empty/pop) carries one token or error per beat.
// Each accepted byte yields zero to three results; end of text yields the
// flushed token, any nesting errors and a final done result (up to four).
// The last result caused by one input beat has last set.
// A result is written into the queue and then loaded into the back-end
// hold register before it is on the ports, and can be popped from there.
// Throughput: one byte per cycle while each byte gives at most one result;
// and results are popped as they come; a byte giving several results holds
// the result side until all are popped, and the two-bundle queue between
// front and back absorbs it. full rises only when that queue is full, so a
// stalled receiver backs up through the queue into full; nothing is dropped.
// Reset (arst_n low) clears the lexer state to line 1, column 0, no token
// pending, and empties the queue and the result stage.
// Rule-name hash is kept with 13x multiply-and-reduce steps on its sum, power and length term for each name byte.
// Uses abnf_lex_pkg, abnf_lex_front, abnf_lex_queue, abnf_lex_back.
module abnf_token_lexer_unit #(
	parameter int HASH_MODULUS = abnf_lex_pkg::HASH_MODULUS_DEF,
	parameter int DEPTH_BITS   = abnf_lex_pkg::DEPTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  token_type,
	output logic [2:0]  error_code,
	output logic [15:0] line_number,
	output logic [15:0] column,
	output logic [15:0] token_length,
	output logic [9:0]  rule_hash,
	output logic        text_done,
	output logic        last
);

	abnf_lex_pkg::lex_bundle_t fr_bundle, q_rdata;
	abnf_lex_pkg::lex_res_t    cur;
	logic fr_push, q_full, q_rvalid, q_pop, acc;

	assign acc  = push && !q_full;
	assign full = q_full;

	abnf_lex_front #(
		.HASH_MODULUS (HASH_MODULUS),
		.DEPTH_BITS   (DEPTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.bundle      (fr_bundle),
		.bundle_push (fr_push)
	);

	abnf_lex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_bundle),
		.full   (q_full),
		.rvalid (q_rvalid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	abnf_lex_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rvalid (q_rvalid),
		.rdata  (q_rdata),
		.rpop   (q_pop),
		.empty  (empty),
		.pop    (pop),
		.cur    (cur),
		.last   (last)
	);

	assign token_type   = cur.token_type;
	assign error_code   = cur.error_code;
	assign line_number  = cur.line_number;
	assign column       = cur.column;
	assign token_length = cur.token_length;
	assign rule_hash    = cur.rule_hash;
	assign text_done    = cur.text_done;

endmodule
